@@ rtl/fqs_pkg.sv @@
// Package for the FIFO queue with content search.
// Request and status codes, widths and the control struct shared by the cells.
// No dependencies.
`default_nettype none
package fqs_pkg;

    localparam int WORD_W = 32;
    localparam int POS_W  = 7;

    typedef enum logic [1:0] {
        REQ_ENQ     = 2'd0,
        REQ_DEQ     = 2'd1,
        REQ_DISPLAY = 2'd2,
        REQ_SEARCH  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic              shift;     // take neighbor's word and hit flag
        logic              mark;      // latch hit flag from match
        logic              mark_all;  // display: every held entry is a hit
        logic [WORD_W-1:0] word;      // word to write, or search key
    } t_cell_ctl;

endpackage
`default_nettype wire

@@ rtl/fifo_queue_with_search.sv @@
// Top level of the FIFO queue with content search: controller and cell chain.
// Depends on fqs_pkg and fqs_cell.
//
// Usage: present i_req_type and i_value with start; the item is taken at a
// clock edge where start is high and busy is low. Results come out on
// o_status, o_element, o_position and o_last, each marked by o_valid for
// one cycle; o_last flags the final result of an item. The receiver cannot
// stall, so results are never held back.
// The queue is a chain of DEPTH cells, oldest word in cell 0. Enqueue writes
// the cell at the fill count; dequeue shifts the chain one cell toward the
// head. Both give their single result the cycle after acceptance and leave
// busy low, so one may follow every cycle.
// Display and search first tag hits in every cell in parallel, then rotate
// all DEPTH cells once through the head (restoring the order); a result
// leaves the cycle after each time the head cell holds a hit. Such an item
// keeps busy high until the rotation ends. Empty queue or no match gives
// one result the cycle after acceptance, with busy low.
// Reset (synchronous, active low) empties the queue and drops any walk.
`default_nettype none
module fifo_queue_with_search #(
    parameter int DEPTH = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         i_req_type,
    input  wire logic signed [31:0] i_value,
    output logic                    o_valid,
    output logic [1:0]              o_status,
    output logic signed [31:0]      o_element,
    output logic [6:0]              o_position,
    output logic                    o_last
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW = fqs_pkg::POS_W;
    localparam int WW = fqs_pkg::WORD_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [SW-1:0]      r_step,  n_step;

    logic               r_valid, n_valid;
    fqs_pkg::t_status   r_status, n_status;
    logic [WW-1:0]      r_element, n_element;
    logic [PW-1:0]      r_position, n_position;
    logic               r_last, n_last;

    fqs_pkg::t_cell_ctl cell_ctl;
    logic [DEPTH-1:0]   wr_sel, cell_valid, hit, match;
    logic [WW-1:0]      cell_data [DEPTH];
    logic               accept;
    fqs_pkg::t_req      req;

    assign accept = start && (r_state == S_IDLE);
    assign req    = fqs_pkg::t_req'(i_req_type);

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WW-1:0] nbr_data;
        logic          nbr_hit;

        if (g == DEPTH - 1) begin : g_tail
            assign nbr_data = cell_data[0];
            assign nbr_hit  = 1'b0;
        end else begin : g_body
            assign nbr_data = cell_data[g+1];
            assign nbr_hit  = hit[g+1];
        end

        assign cell_valid[g] = (CW'(g) < r_count);

        fqs_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (cell_ctl),
            .i_wr_sel   (wr_sel[g]),
            .i_valid    (cell_valid[g]),
            .i_nbr_data (nbr_data),
            .i_nbr_hit  (nbr_hit),
            .o_data     (cell_data[g]),
            .o_hit      (hit[g]),
            .o_match    (match[g])
        );
    end

    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_step         = r_step;
        n_valid        = 1'b0;
        n_status       = fqs_pkg::ST_OK;
        n_element      = '0;
        n_position     = '0;
        n_last         = 1'b1;
        cell_ctl.shift    = 1'b0;
        cell_ctl.mark     = 1'b0;
        cell_ctl.mark_all = (req == fqs_pkg::REQ_DISPLAY);
        cell_ctl.word     = WW'(i_value);
        wr_sel         = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_valid = 1'b1;
                    unique case (req)
                        fqs_pkg::REQ_ENQ: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_status = fqs_pkg::ST_FULL;
                            end else begin
                                for (int k = 0; k < DEPTH; k++) begin
                                    wr_sel[k] = (r_count == CW'(k));
                                end
                                n_count    = r_count + CW'(1);
                                n_element  = WW'(i_value);
                                n_position = PW'(r_count) + PW'(1);
                            end
                        end
                        fqs_pkg::REQ_DEQ: begin
                            if (r_count == '0) begin
                                n_status = fqs_pkg::ST_EMPTY;
                            end else begin
                                cell_ctl.shift = 1'b1;
                                n_count    = r_count - CW'(1);
                                n_element  = cell_data[0];
                                n_position = PW'(1);
                            end
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_status = fqs_pkg::ST_EMPTY;
                            end else if (match == '0) begin
                                n_status = fqs_pkg::ST_NOTFOUND;
                            end else begin
                                n_valid       = 1'b0;
                                cell_ctl.mark = 1'b1;
                                n_step        = '0;
                                n_state       = S_WALK;
                            end
                        end
                    endcase
                end
            end
            S_WALK: begin
                cell_ctl.shift = 1'b1;
                n_valid        = hit[0];
                n_element      = cell_data[0];
                n_position     = PW'(r_step) + PW'(1);
                n_last         = ((hit >> 1) == '0);
                n_step         = r_step + SW'(1);
                if (r_step == SW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_step  <= n_step;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_element  <= n_element;
        r_position <= n_position;
        r_last     <= n_last;
    end

    assign busy       = (r_state == S_WALK);
    assign o_valid    = r_valid;
    assign o_status   = r_status;
    assign o_element  = r_element;
    assign o_position = r_position;
    assign o_last     = r_last;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count above depth");

    a_walk_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |=> (r_count == $past(r_count)))
        else $error("fill count changed during a walk");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (req == fqs_pkg::REQ_ENQ || req == fqs_pkg::REQ_DEQ))
        |=> (o_valid && o_last))
        else $error("enqueue or dequeue without a final result");

    a_walk_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> ($past(r_step) == SW'(DEPTH - 1)))
        else $error("walk ended before a full rotation");

    a_walk_ends_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && hit[0] && ((hit >> 1) == '0)) |=> (o_valid && o_last))
        else $error("final hit left without last flag");

endmodule
`default_nettype wire

@@ rtl/fqs_cell.sv @@
// One storage cell of the queue chain: a word and a hit flag.
// Depends on fqs_pkg.
`default_nettype none
module fqs_cell (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire fqs_pkg::t_cell_ctl          i_ctl,
    input  wire logic                        i_wr_sel,
    input  wire logic                        i_valid,
    input  wire logic [fqs_pkg::WORD_W-1:0]  i_nbr_data,
    input  wire logic                        i_nbr_hit,
    output logic      [fqs_pkg::WORD_W-1:0]  o_data,
    output logic                             o_hit,
    output logic                             o_match
);

    logic [fqs_pkg::WORD_W-1:0] r_data;
    logic                       r_hit;

    always_comb begin
        o_match = i_valid && (i_ctl.mark_all || (r_data == i_ctl.word));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_data <= i_nbr_data;
        end else if (i_wr_sel) begin
            r_data <= i_ctl.word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctl.shift) begin
            r_hit <= i_nbr_hit;
        end else if (i_ctl.mark) begin
            r_hit <= o_match;
        end
    end

    assign o_data = r_data;
    assign o_hit  = r_hit;

endmodule
`default_nettype wire
